// ----- rtl/core/nc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Narrowphase collision package
// Shared constants and the flag word that travels with each pair down the
// datapath.
// ----------------------------------------------------------------------------
package nc_pkg;

  // Default geometry and normal precision.
  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;

  // Fixed result field widths and saturation limits.
  localparam int NRM_W       = 16;
  localparam int DEPTH_W     = 24;
  localparam int MTV_W       = 25;
  localparam int DEPTH_MAX   = 16777215;
  localparam int MTV_MAX     = 16777215;
  localparam int NRM_MAX     = 32767;
  localparam int NRM_MIN_MAG = 32768;

  // Per-pair flags carried alongside the arithmetic.
  typedef struct packed {
    logic box;    // box-box pair
    logic cc;     // circle-circle pair
    logic cb;     // circle-box pair
    logic hit;    // overlap found (partial until the distance check)
    logic zero;   // coincident points, normal is fixed
    logic neg_x;  // normal x is negative
    logic neg_y;  // normal y is negative
    logic eq_x;   // all of the distance lies on x
    logic eq_y;   // all of the distance lies on y
  } nc_flags_t;

endpackage

// ----- rtl/core/nc_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Narrowphase collision channels
// Valid/ready channels for the shape-pair word and the contact result word.
// ----------------------------------------------------------------------------
interface nc_in_if #(
  parameter int CB = nc_pkg::COORD_BITS
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic signed [CB-1:0] first_x;
  logic signed [CB-1:0] first_y;
  logic signed [CB-1:0] first_ext_x;
  logic signed [CB-1:0] first_ext_y;
  logic signed [CB-1:0] second_x;
  logic signed [CB-1:0] second_y;
  logic signed [CB-1:0] second_ext_x;
  logic signed [CB-1:0] second_ext_y;

  modport source (
    output valid, req_type, first_x, first_y, first_ext_x, first_ext_y,
           second_x, second_y, second_ext_x, second_ext_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, first_x, first_y, first_ext_x, first_ext_y,
           second_x, second_y, second_ext_x, second_ext_y,
    output ready
  );
endinterface

interface nc_out_if;
  import nc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic [DEPTH_W-1:0]      depth;
  logic signed [MTV_W-1:0] mtv_x;
  logic signed [MTV_W-1:0] mtv_y;

  modport source (
    output valid, hit, normal_x, normal_y, depth, mtv_x, mtv_y,
    input  ready
  );
  modport sink (
    input  valid, hit, normal_x, normal_y, depth, mtv_x, mtv_y,
    output ready
  );
endinterface

// ----- rtl/core/nc_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Narrowphase pair preparation
// Four pipeline stages: offsets, range checks and box axis choice, squares,
// and the squared-distance test that settles the hit.
// ----------------------------------------------------------------------------
module nc_prep #(
  parameter int CB = nc_pkg::COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  nc_in_if.sink                             in_ch,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output nc_pkg::nc_flags_t                 dn_flags,
  output logic [2*CB-1:0]                   dn_d2,
  output logic [2*CB-1:0]                   dn_sx2,
  output logic [2*CB-1:0]                   dn_sy2,
  output logic [CB-1:0]                     dn_rs,
  output logic signed [nc_pkg::MTV_W-1:0]   dn_mtv_x,
  output logic signed [nc_pkg::MTV_W-1:0]   dn_mtv_y
);
  import nc_pkg::*;

  localparam int W2 = 2 * CB;
  localparam logic [1:0] KIND_CC  = 2'd0;
  localparam logic [1:0] KIND_BOX = 2'd1;
  localparam logic [1:0] KIND_CB  = 2'd2;

  // Clamp a radius to zero when negative.
  function automatic logic [CB-2:0] nn(input logic signed [CB-1:0] a);
    return a[CB-1] ? '0 : a[CB-2:0];
  endfunction

  logic signed [CB:0] ax_e, ay_e, aex_e, aey_e, bx_e, by_e, bex_e, bey_e;
  logic signed [CB-1:0] cx, cy;
  logic signed [CB:0] cx_e, cy_e;

  // Stage 0 registers.
  logic              v0_r, rdy0;
  nc_flags_t         f0_r, f0_nxt;
  logic signed [CB:0] dx0_r, dx0_nxt, dy0_r, dy0_nxt;
  logic [CB-1:0]     rad0_r, rad0_nxt;
  logic signed [CB:0] px0_r, qx0_r, py0_r, qy0_r;

  // Stage 1 registers.
  logic              v1_r, rdy1;
  nc_flags_t         f1_r, f1_nxt;
  logic [CB-1:0]     adx1_r, adx1_nxt, ady1_r, ady1_nxt, rad1_r;
  logic signed [MTV_W-1:0] mx1_r, mx1_nxt, my1_r, my1_nxt;

  // Stage 2 registers.
  logic              v2_r, rdy2;
  nc_flags_t         f2_r;
  logic [W2-1:0]     sx2_r, sy2_r, r2_r;
  logic [CB-1:0]     rad2_r;
  logic signed [MTV_W-1:0] mx2_r, my2_r;

  // Stage 3 registers.
  logic              v3_r, rdy3;
  nc_flags_t         f3_r, f3_nxt;
  logic [W2-1:0]     d2_r, sx2o_r, sy2o_r;
  logic [CB-1:0]     rad3_r;
  logic signed [MTV_W-1:0] mx3_r, my3_r;

  // Stage 1 combinational terms.
  logic [CB:0]       adx, ady, rad_e;
  logic              ok_cc, ok_cb, boxhit, c1, c2, c3, bneg, baxis_x;
  logic [CB-1:0]     bmag;
  logic [32:0]       bmag33;
  logic [MTV_W-2:0]  bsat;
  logic signed [MTV_W-1:0] bval;

  // Stage 3 combinational terms.
  logic [W2:0]       d2s;
  logic              in_range;

  // Sign-extended coordinates and the clamped box point.
  assign ax_e  = {in_ch.first_x[CB-1], in_ch.first_x};
  assign ay_e  = {in_ch.first_y[CB-1], in_ch.first_y};
  assign aex_e = {in_ch.first_ext_x[CB-1], in_ch.first_ext_x};
  assign aey_e = {in_ch.first_ext_y[CB-1], in_ch.first_ext_y};
  assign bx_e  = {in_ch.second_x[CB-1], in_ch.second_x};
  assign by_e  = {in_ch.second_y[CB-1], in_ch.second_y};
  assign bex_e = {in_ch.second_ext_x[CB-1], in_ch.second_ext_x};
  assign bey_e = {in_ch.second_ext_y[CB-1], in_ch.second_ext_y};
  assign cx = (in_ch.first_x < in_ch.second_x) ? in_ch.second_x :
              ((in_ch.first_x > in_ch.second_ext_x) ? in_ch.second_ext_x : in_ch.first_x);
  assign cy = (in_ch.first_y < in_ch.second_y) ? in_ch.second_y :
              ((in_ch.first_y > in_ch.second_ext_y) ? in_ch.second_ext_y : in_ch.first_y);
  assign cx_e = {cx[CB-1], cx};
  assign cy_e = {cy[CB-1], cy};

  // Stall chain: a stage takes a new word when empty or when it drains.
  assign rdy0        = !v0_r || rdy1;
  assign rdy1        = !v1_r || rdy2;
  assign rdy2        = !v2_r || rdy3;
  assign rdy3        = !dn_valid || dn_ready;
  assign in_ch.ready = rdy0;

  // Stage 0: centre offsets and radius per pair kind.
  always_comb begin
    f0_nxt   = '0;
    dx0_nxt  = '0;
    dy0_nxt  = '0;
    rad0_nxt = '0;
    unique case (in_ch.req_type)
      KIND_CC: begin
        f0_nxt.cc = 1'b1;
        dx0_nxt   = bx_e - ax_e;
        dy0_nxt   = by_e - ay_e;
        rad0_nxt  = {1'b0, nn(in_ch.first_ext_x)} + {1'b0, nn(in_ch.second_ext_x)};
      end
      KIND_BOX: begin
        f0_nxt.box = 1'b1;
      end
      KIND_CB: begin
        f0_nxt.cb = 1'b1;
        dx0_nxt   = ax_e - cx_e;
        dy0_nxt   = ay_e - cy_e;
        rad0_nxt  = {1'b0, nn(in_ch.first_ext_x)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      f0_r   <= f0_nxt;
      dx0_r  <= dx0_nxt;
      dy0_r  <= dy0_nxt;
      rad0_r <= rad0_nxt;
      px0_r  <= bex_e - ax_e;
      qx0_r  <= aex_e - bx_e;
      py0_r  <= bey_e - ay_e;
      qy0_r  <= aey_e - by_e;
    end
  end

  // Stage 1: range checks for circles, least-penetration axis for boxes.
  always_comb begin
    adx    = dx0_r[CB] ? (CB+1)'(-dx0_r) : (CB+1)'(dx0_r);
    ady    = dy0_r[CB] ? (CB+1)'(-dy0_r) : (CB+1)'(dy0_r);
    rad_e  = {1'b0, rad0_r};
    ok_cc  = (adx < rad_e) && (ady < rad_e);
    ok_cb  = (adx <= rad_e) && (ady <= rad_e);
    boxhit = (px0_r > 0) && (qx0_r > 0) && (py0_r > 0) && (qy0_r > 0);
    c1     = (px0_r < qx0_r) && (px0_r < py0_r) && (px0_r < qy0_r);
    c2     = (qx0_r < py0_r) && (qx0_r < qy0_r);
    c3     = (py0_r < qy0_r);
    if (c1) begin
      bmag = px0_r[CB-1:0]; bneg = 1'b0; baxis_x = 1'b1;
    end else if (c2) begin
      bmag = qx0_r[CB-1:0]; bneg = 1'b1; baxis_x = 1'b1;
    end else if (c3) begin
      bmag = py0_r[CB-1:0]; bneg = 1'b0; baxis_x = 1'b0;
    end else begin
      bmag = qy0_r[CB-1:0]; bneg = 1'b1; baxis_x = 1'b0;
    end
    bmag33 = 33'(bmag);
    bsat   = (bmag33 > 33'(MTV_MAX)) ? (MTV_W-1)'(MTV_MAX) : (MTV_W-1)'(bmag33);
    bval   = bneg ? -$signed({1'b0, bsat}) : $signed({1'b0, bsat});

    f1_nxt       = f0_r;
    f1_nxt.hit   = f0_r.box ? boxhit : ((f0_r.cc && ok_cc) || (f0_r.cb && ok_cb));
    f1_nxt.neg_x = dx0_r[CB];
    f1_nxt.neg_y = dy0_r[CB];
    f1_nxt.eq_x  = (ady == '0);
    f1_nxt.eq_y  = (adx == '0);
    adx1_nxt     = (f1_nxt.hit && !f0_r.box) ? adx[CB-1:0] : '0;
    ady1_nxt     = (f1_nxt.hit && !f0_r.box) ? ady[CB-1:0] : '0;
    mx1_nxt      = (f0_r.box && boxhit && baxis_x) ? bval : '0;
    my1_nxt      = (f0_r.box && boxhit && !baxis_x) ? bval : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      f1_r   <= f1_nxt;
      adx1_r <= adx1_nxt;
      ady1_r <= ady1_nxt;
      rad1_r <= rad0_r;
      mx1_r  <= mx1_nxt;
      my1_r  <= my1_nxt;
    end
  end

  // Stage 2: squares of the offsets and of the radius.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      f2_r   <= f1_r;
      sx2_r  <= adx1_r * adx1_r;
      sy2_r  <= ady1_r * ady1_r;
      r2_r   <= rad1_r * rad1_r;
      rad2_r <= rad1_r;
      mx2_r  <= mx1_r;
      my2_r  <= my1_r;
    end
  end

  // Stage 3: squared distance against squared radius.
  always_comb begin
    d2s      = {1'b0, sx2_r} + {1'b0, sy2_r};
    in_range = f2_r.cc ? (d2s < {1'b0, r2_r}) : (d2s <= {1'b0, r2_r});
    f3_nxt      = f2_r;
    f3_nxt.hit  = f2_r.box ? f2_r.hit : (f2_r.hit && in_range);
    f3_nxt.zero = (d2s == '0) && !f2_r.box;
    if (f2_r.cb && d2s == '0) begin
      f3_nxt.neg_x = 1'b0;
      f3_nxt.neg_y = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      f3_r   <= f3_nxt;
      d2_r   <= d2s[W2-1:0];
      sx2o_r <= sx2_r;
      sy2o_r <= sy2_r;
      rad3_r <= rad2_r;
      mx3_r  <= mx2_r;
      my3_r  <= my2_r;
    end
  end

  assign dn_valid = v3_r;
  assign dn_flags = f3_r;
  assign dn_d2    = d2_r;
  assign dn_sx2   = sx2o_r;
  assign dn_sy2   = sy2o_r;
  assign dn_rs    = rad3_r;
  assign dn_mtv_x = mx3_r;
  assign dn_mtv_y = my3_r;

endmodule

// ----- rtl/core/nc_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Narrowphase divide/root cell
// One restoring division step on each squared component over the squared
// distance, and one digit of the square root of the squared distance.
// ----------------------------------------------------------------------------
module nc_div_cell #(
  parameter int CB  = nc_pkg::COORD_BITS,
  parameter int NF  = nc_pkg::NORMAL_FRAC_BITS,
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  nc_pkg::nc_flags_t               up_flags,
  input  logic [2*CB-1:0]                 up_d2,
  input  logic [2*CB-1:0]                 up_remx,
  input  logic [2*CB-1:0]                 up_remy,
  input  logic [2*NF-1:0]                 up_qx,
  input  logic [2*NF-1:0]                 up_qy,
  input  logic [2*CB-1:0]                 up_sv,
  input  logic [2*CB-1:0]                 up_sr,
  input  logic [CB-1:0]                   up_rs,
  input  logic signed [nc_pkg::MTV_W-1:0] up_mtv_x,
  input  logic signed [nc_pkg::MTV_W-1:0] up_mtv_y,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output nc_pkg::nc_flags_t               dn_flags,
  output logic [2*CB-1:0]                 dn_d2,
  output logic [2*CB-1:0]                 dn_remx,
  output logic [2*CB-1:0]                 dn_remy,
  output logic [2*NF-1:0]                 dn_qx,
  output logic [2*NF-1:0]                 dn_qy,
  output logic [2*CB-1:0]                 dn_sv,
  output logic [2*CB-1:0]                 dn_sr,
  output logic [CB-1:0]                   dn_rs,
  output logic signed [nc_pkg::MTV_W-1:0] dn_mtv_x,
  output logic signed [nc_pkg::MTV_W-1:0] dn_mtv_y
);
  import nc_pkg::*;

  localparam int W2     = 2 * CB;
  localparam bit DO_DIV = (IDX < 2 * NF);
  localparam bit DO_SQ  = (IDX < CB);
  localparam int SQ_SH  = DO_SQ ? 2 * (CB - 1 - IDX) : 0;
  localparam logic [W2:0] SQ_BIT = {{W2{1'b0}}, 1'b1} << SQ_SH;

  logic              v_r;
  nc_flags_t         f_r;
  logic [W2-1:0]     d2_r, remx_r, remx_nxt, remy_r, remy_nxt;
  logic [W2-1:0]     sv_r, sv_nxt, sr_r, sr_nxt;
  logic [2*NF-1:0]   qx_r, qx_nxt, qy_r, qy_nxt;
  logic [CB-1:0]     rs_r;
  logic signed [MTV_W-1:0] mx_r, my_r;

  logic [W2:0]       rx2, ry2, den, t, sv_e;
  logic              gx, gy, gs;

  assign up_ready = !v_r || dn_ready;

  // Division digit on each component, root digit on the distance.
  always_comb begin
    den  = {1'b0, up_d2};
    rx2  = {up_remx, 1'b0};
    ry2  = {up_remy, 1'b0};
    gx   = (rx2 >= den);
    gy   = (ry2 >= den);
    t    = {1'b0, up_sr} + SQ_BIT;
    sv_e = {1'b0, up_sv};
    gs   = (sv_e >= t);
    if (DO_DIV) begin
      remx_nxt = gx ? W2'(rx2 - den) : rx2[W2-1:0];
      remy_nxt = gy ? W2'(ry2 - den) : ry2[W2-1:0];
      qx_nxt   = {up_qx[2*NF-2:0], gx};
      qy_nxt   = {up_qy[2*NF-2:0], gy};
    end else begin
      remx_nxt = up_remx;
      remy_nxt = up_remy;
      qx_nxt   = up_qx;
      qy_nxt   = up_qy;
    end
    if (DO_SQ) begin
      sv_nxt = gs ? W2'(sv_e - t) : up_sv;
      sr_nxt = gs ? W2'(({1'b0, up_sr} >> 1) + SQ_BIT) : (up_sr >> 1);
    end else begin
      sv_nxt = up_sv;
      sr_nxt = up_sr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      f_r    <= up_flags;
      d2_r   <= up_d2;
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      sv_r   <= sv_nxt;
      sr_r   <= sr_nxt;
      rs_r   <= up_rs;
      mx_r   <= up_mtv_x;
      my_r   <= up_mtv_y;
    end
  end

  assign dn_valid = v_r;
  assign dn_flags = f_r;
  assign dn_d2    = d2_r;
  assign dn_remx  = remx_r;
  assign dn_remy  = remy_r;
  assign dn_qx    = qx_r;
  assign dn_qy    = qy_r;
  assign dn_sv    = sv_r;
  assign dn_sr    = sr_r;
  assign dn_rs    = rs_r;
  assign dn_mtv_x = mx_r;
  assign dn_mtv_y = my_r;

endmodule

// ----- rtl/core/nc_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Narrowphase normal root cell
// One digit of the square roots of the two scaled ratios that form the
// normal components.
// ----------------------------------------------------------------------------
module nc_sqrt_cell #(
  parameter int CB  = nc_pkg::COORD_BITS,
  parameter int NF  = nc_pkg::NORMAL_FRAC_BITS,
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  nc_pkg::nc_flags_t               up_flags,
  input  logic [2*NF+1:0]                 up_vx,
  input  logic [2*NF+1:0]                 up_rx,
  input  logic [2*NF+1:0]                 up_vy,
  input  logic [2*NF+1:0]                 up_ry,
  input  logic [CB:0]                     up_dist,
  input  logic [CB-1:0]                   up_rs,
  input  logic signed [nc_pkg::MTV_W-1:0] up_mtv_x,
  input  logic signed [nc_pkg::MTV_W-1:0] up_mtv_y,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output nc_pkg::nc_flags_t               dn_flags,
  output logic [2*NF+1:0]                 dn_vx,
  output logic [2*NF+1:0]                 dn_rx,
  output logic [2*NF+1:0]                 dn_vy,
  output logic [2*NF+1:0]                 dn_ry,
  output logic [CB:0]                     dn_dist,
  output logic [CB-1:0]                   dn_rs,
  output logic signed [nc_pkg::MTV_W-1:0] dn_mtv_x,
  output logic signed [nc_pkg::MTV_W-1:0] dn_mtv_y
);
  import nc_pkg::*;

  localparam int WQ = 2 * NF + 2;
  localparam logic [WQ:0] BIT = {{WQ{1'b0}}, 1'b1} << (2 * (NF - IDX));

  logic              v_r;
  nc_flags_t         f_r;
  logic [WQ-1:0]     vx_r, rx_r, vy_r, ry_r;
  logic [WQ-1:0]     vx_nxt, rx_nxt, vy_nxt, ry_nxt;
  logic [CB:0]       dist_r;
  logic [CB-1:0]     rs_r;
  logic signed [MTV_W-1:0] mx_r, my_r;
  logic [WQ:0]       tx, ty;
  logic              gx, gy;

  assign up_ready = !v_r || dn_ready;

  // Root digit on both components.
  always_comb begin
    tx     = {1'b0, up_rx} + BIT;
    ty     = {1'b0, up_ry} + BIT;
    gx     = ({1'b0, up_vx} >= tx);
    gy     = ({1'b0, up_vy} >= ty);
    vx_nxt = gx ? WQ'({1'b0, up_vx} - tx) : up_vx;
    vy_nxt = gy ? WQ'({1'b0, up_vy} - ty) : up_vy;
    rx_nxt = gx ? WQ'(({1'b0, up_rx} >> 1) + BIT) : (up_rx >> 1);
    ry_nxt = gy ? WQ'(({1'b0, up_ry} >> 1) + BIT) : (up_ry >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      f_r    <= up_flags;
      vx_r   <= vx_nxt;
      rx_r   <= rx_nxt;
      vy_r   <= vy_nxt;
      ry_r   <= ry_nxt;
      dist_r <= up_dist;
      rs_r   <= up_rs;
      mx_r   <= up_mtv_x;
      my_r   <= up_mtv_y;
    end
  end

  assign dn_valid = v_r;
  assign dn_flags = f_r;
  assign dn_vx    = vx_r;
  assign dn_rx    = rx_r;
  assign dn_vy    = vy_r;
  assign dn_ry    = ry_r;
  assign dn_dist  = dist_r;
  assign dn_rs    = rs_r;
  assign dn_mtv_x = mx_r;
  assign dn_mtv_y = my_r;

endmodule

// ----- rtl/core/nc_finish.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Narrowphase result stage
// Rounds the normal, forms the depth, saturates both of them and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
module nc_finish #(
  parameter int CB = nc_pkg::COORD_BITS,
  parameter int NF = nc_pkg::NORMAL_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  nc_pkg::nc_flags_t               up_flags,
  input  logic [2*NF+1:0]                 up_vx,
  input  logic [2*NF+1:0]                 up_rx,
  input  logic [2*NF+1:0]                 up_vy,
  input  logic [2*NF+1:0]                 up_ry,
  input  logic [CB:0]                     up_dist,
  input  logic [CB-1:0]                   up_rs,
  input  logic signed [nc_pkg::MTV_W-1:0] up_mtv_x,
  input  logic signed [nc_pkg::MTV_W-1:0] up_mtv_y,
  nc_out_if.source                        out_ch
);
  import nc_pkg::*;

  localparam int WQ = 2 * NF + 2;
  localparam logic [WQ-1:0] ONE = {{(WQ-1){1'b0}}, 1'b1} << NF;

  // Signed normal component with saturation to the 16-bit range.
  function automatic logic signed [NRM_W-1:0] sat_nrm(input logic [WQ-1:0] mag,
                                                      input logic neg);
    logic signed [NRM_W-1:0] res;
    if (!neg) begin
      res = (mag > WQ'(NRM_MAX)) ? NRM_W'(NRM_MAX) : NRM_W'(mag);
    end else begin
      res = (mag > WQ'(NRM_MIN_MAG)) ? NRM_W'(NRM_MIN_MAG) : -NRM_W'(mag);
    end
    return res;
  endfunction

  logic              v_r;
  logic              hit_r;
  logic signed [NRM_W-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic signed [MTV_W-1:0] mx_r, mx_nxt, my_r, my_nxt;

  logic [WQ-1:0]     rndx, rndy, magx, magy;
  logic [CB+1:0]     diff;
  logic [32:0]       diff33;

  assign up_ready = !v_r || out_ch.ready;

  // Round the roots, pick fixed normals for coincident points, form depth.
  always_comb begin
    rndx   = up_rx + WQ'(up_vx > up_rx);
    rndy   = up_ry + WQ'(up_vy > up_ry);
    magx   = up_flags.zero ? (up_flags.cc ? ONE : '0) : rndx;
    magy   = up_flags.zero ? (up_flags.cc ? '0 : ONE) : rndy;
    diff   = {2'b00, up_rs} - {1'b0, up_dist};
    diff33 = 33'(diff[CB:0]);
    nx_nxt    = '0;
    ny_nxt    = '0;
    depth_nxt = '0;
    mx_nxt    = '0;
    my_nxt    = '0;
    if (up_flags.hit) begin
      if (up_flags.box) begin
        mx_nxt = up_mtv_x;
        my_nxt = up_mtv_y;
      end else begin
        nx_nxt = sat_nrm(magx, up_flags.neg_x);
        ny_nxt = sat_nrm(magy, up_flags.neg_y);
        if (!diff[CB+1]) begin
          depth_nxt = (diff33 > 33'(DEPTH_MAX)) ? DEPTH_W'(DEPTH_MAX) : DEPTH_W'(diff33);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      hit_r   <= up_flags.hit;
      nx_r    <= nx_nxt;
      ny_r    <= ny_nxt;
      depth_r <= depth_nxt;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
    end
  end

  assign out_ch.valid    = v_r;
  assign out_ch.hit      = hit_r;
  assign out_ch.normal_x = nx_r;
  assign out_ch.normal_y = ny_r;
  assign out_ch.depth    = depth_r;
  assign out_ch.mtv_x    = mx_r;
  assign out_ch.mtv_y    = my_r;

endmodule

// ----- rtl/core/narrowphase_collision_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Narrowphase collision test
// Circle-circle, box-box and circle-box overlap test with contact normal,
// penetration depth and minimum translation vector.
// ----------------------------------------------------------------------------
// The unit takes one shape-pair word per clock while no stall holds it back
// and returns one result word per pair, in order. Four preparation stages
// are followed by a row of divide/root cells, one per quotient bit of the
// normal ratios or per root digit of the distance, whichever is more, and
// a row of root cells, one per bit of the normal; every cell holds its own
// word, so a full pipeline sustains one pair per cycle when the result
// channel does not stall. Each stage has its own valid bit and takes a new
// word whenever it is empty or draining, so back-pressure on the result
// channel only stalls the pipeline once it has filled up. The unit keeps no
// state between pairs.
module narrowphase_collision_test #(
  parameter int COORD_BITS       = nc_pkg::COORD_BITS,
  parameter int NORMAL_FRAC_BITS = nc_pkg::NORMAL_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  nc_in_if.sink     in_ch,
  nc_out_if.source  out_ch
);
  import nc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int NF = NORMAL_FRAC_BITS;
  localparam int W2 = 2 * CB;
  localparam int WQ = 2 * NF + 2;
  localparam int LA = (2 * NF > CB) ? 2 * NF : CB;
  localparam int NB = NF + 1;

  // Divide/root row.
  logic              a_valid [0:LA];
  logic              a_ready [0:LA];
  nc_flags_t         a_flags [0:LA];
  logic [W2-1:0]     a_d2    [0:LA];
  logic [W2-1:0]     a_remx  [0:LA];
  logic [W2-1:0]     a_remy  [0:LA];
  logic [2*NF-1:0]   a_qx    [0:LA];
  logic [2*NF-1:0]   a_qy    [0:LA];
  logic [W2-1:0]     a_sv    [0:LA];
  logic [W2-1:0]     a_sr    [0:LA];
  logic [CB-1:0]     a_rs    [0:LA];
  logic signed [MTV_W-1:0] a_mx [0:LA];
  logic signed [MTV_W-1:0] a_my [0:LA];

  // Normal root row.
  logic              b_valid [0:NB];
  logic              b_ready [0:NB];
  nc_flags_t         b_flags [0:NB];
  logic [WQ-1:0]     b_vx    [0:NB];
  logic [WQ-1:0]     b_rx    [0:NB];
  logic [WQ-1:0]     b_vy    [0:NB];
  logic [WQ-1:0]     b_ry    [0:NB];
  logic [CB:0]       b_dist  [0:NB];
  logic [CB-1:0]     b_rs    [0:NB];
  logic signed [MTV_W-1:0] b_mx [0:NB];
  logic signed [MTV_W-1:0] b_my [0:NB];

  // Preparation stages feed the head of the divide/root row.
  nc_prep #(.CB(CB)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (a_valid[0]),
    .dn_ready (a_ready[0]),
    .dn_flags (a_flags[0]),
    .dn_d2    (a_d2[0]),
    .dn_sx2   (a_remx[0]),
    .dn_sy2   (a_remy[0]),
    .dn_rs    (a_rs[0]),
    .dn_mtv_x (a_mx[0]),
    .dn_mtv_y (a_my[0])
  );
  assign a_qx[0] = '0;
  assign a_qy[0] = '0;
  assign a_sv[0] = a_d2[0];
  assign a_sr[0] = '0;

  for (genvar i = 0; i < LA; i++) begin : g_div
    nc_div_cell #(.CB(CB), .NF(NF), .IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (a_valid[i]),
      .up_ready (a_ready[i]),
      .up_flags (a_flags[i]),
      .up_d2    (a_d2[i]),
      .up_remx  (a_remx[i]),
      .up_remy  (a_remy[i]),
      .up_qx    (a_qx[i]),
      .up_qy    (a_qy[i]),
      .up_sv    (a_sv[i]),
      .up_sr    (a_sr[i]),
      .up_rs    (a_rs[i]),
      .up_mtv_x (a_mx[i]),
      .up_mtv_y (a_my[i]),
      .dn_valid (a_valid[i+1]),
      .dn_ready (a_ready[i+1]),
      .dn_flags (a_flags[i+1]),
      .dn_d2    (a_d2[i+1]),
      .dn_remx  (a_remx[i+1]),
      .dn_remy  (a_remy[i+1]),
      .dn_qx    (a_qx[i+1]),
      .dn_qy    (a_qy[i+1]),
      .dn_sv    (a_sv[i+1]),
      .dn_sr    (a_sr[i+1]),
      .dn_rs    (a_rs[i+1]),
      .dn_mtv_x (a_mx[i+1]),
      .dn_mtv_y (a_my[i+1])
    );
  end

  // Between the rows: a full ratio when one axis carries all the distance,
  // and the distance rounded to nearest.
  assign b_valid[0]   = a_valid[LA];
  assign a_ready[LA]  = b_ready[0];
  assign b_flags[0]   = a_flags[LA];
  assign b_vx[0]      = a_flags[LA].eq_x ? (WQ'(1) << (2 * NF)) : {2'b00, a_qx[LA]};
  assign b_vy[0]      = a_flags[LA].eq_y ? (WQ'(1) << (2 * NF)) : {2'b00, a_qy[LA]};
  assign b_rx[0]      = '0;
  assign b_ry[0]      = '0;
  assign b_dist[0]    = {1'b0, a_sr[LA][CB-1:0]} + (CB+1)'(a_sv[LA] > a_sr[LA]);
  assign b_rs[0]      = a_rs[LA];
  assign b_mx[0]      = a_mx[LA];
  assign b_my[0]      = a_my[LA];

  for (genvar j = 0; j < NB; j++) begin : g_root
    nc_sqrt_cell #(.CB(CB), .NF(NF), .IDX(j)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (b_valid[j]),
      .up_ready (b_ready[j]),
      .up_flags (b_flags[j]),
      .up_vx    (b_vx[j]),
      .up_rx    (b_rx[j]),
      .up_vy    (b_vy[j]),
      .up_ry    (b_ry[j]),
      .up_dist  (b_dist[j]),
      .up_rs    (b_rs[j]),
      .up_mtv_x (b_mx[j]),
      .up_mtv_y (b_my[j]),
      .dn_valid (b_valid[j+1]),
      .dn_ready (b_ready[j+1]),
      .dn_flags (b_flags[j+1]),
      .dn_vx    (b_vx[j+1]),
      .dn_rx    (b_rx[j+1]),
      .dn_vy    (b_vy[j+1]),
      .dn_ry    (b_ry[j+1]),
      .dn_dist  (b_dist[j+1]),
      .dn_rs    (b_rs[j+1]),
      .dn_mtv_x (b_mx[j+1]),
      .dn_mtv_y (b_my[j+1])
    );
  end

  // Result stage and output register.
  nc_finish #(.CB(CB), .NF(NF)) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (b_valid[NB]),
    .up_ready (b_ready[NB]),
    .up_flags (b_flags[NB]),
    .up_vx    (b_vx[NB]),
    .up_rx    (b_rx[NB]),
    .up_vy    (b_vy[NB]),
    .up_ry    (b_ry[NB]),
    .up_dist  (b_dist[NB]),
    .up_rs    (b_rs[NB]),
    .up_mtv_x (b_mx[NB]),
    .up_mtv_y (b_my[NB]),
    .out_ch   (out_ch)
  );

endmodule
